/* hw/rtl/sme_pkg.sv */
// ============================================================================
// sme_pkg: shared types and constants of the instruction execute block
// Opcodes, the request payloads of both channels and field widths.
// ============================================================================
package sme_pkg;

    localparam int INSTR_W = 16;
    localparam int BYTE_W  = 8;
    localparam int RIDX_W  = 4;

    // Supported opcodes. Every other opcode value is illegal.
    localparam logic [3:0] OP_LOAD_MEM = 4'h1;
    localparam logic [3:0] OP_LOAD_IMM = 4'h2;
    localparam logic [3:0] OP_STORE    = 4'h3;
    localparam logic [3:0] OP_MOVE     = 4'h4;
    localparam logic [3:0] OP_ADD      = 4'h5;
    localparam logic [3:0] OP_JUMP     = 4'hB;
    localparam logic [3:0] OP_HALT     = 4'hC;

    typedef struct packed {
        logic [INSTR_W-1:0] instruction;
    } instr_t;

    typedef struct packed {
        logic [BYTE_W-1:0] next_pc;
        logic              halted;
        logic              illegal;
        logic              reg_write;
        logic [RIDX_W-1:0] reg_index;
        logic [BYTE_W-1:0] reg_value;
    } result_t;

endpackage

/* hw/rtl/sme_stream_if.sv */
// ============================================================================
// sme_stream_if: valid/ready request channel
// Carries one payload of a configurable type per accepted request.
// ============================================================================
interface sme_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

/* hw/rtl/simple_machine_instruction_execute_top.sv */
// ============================================================================
// simple_machine_instruction_execute_top: teaching machine execute stage
// Executes one 16-bit instruction per request over sixteen 8-bit registers,
// a 256-byte data memory, a program counter and a sticky halt flag.
// ============================================================================
//
//   Channel  Direction  Payload                                      Width
//   -------  ---------  -------------------------------------------  -----
//   instr    sink       instruction                                  16
//   result   source     next_pc, halted, illegal, reg_write,         23
//                       reg_index, reg_value
//
// A request is taken every cycle unless a stalled result holds the execute
// register. When an instruction is accepted, its operand addresses go to the
// register file and data memory read ports, whose read data is registered;
// in the next cycle it executes from the execute register, and its result
// enters the output register once free; unstalled throughput is one per clock.
// Reset clears the program counter, the halt flag and the valid bits that
// make never-written registers and memory bytes read as zero; no clearing
// pass is needed. A stalled result holds the execute register, and a new
// request is taken whenever the output register is free or being drained.
//
module simple_machine_instruction_execute_top #(
    parameter int NUM_REGS  = 16,
    parameter int MEM_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    sme_stream_if.sink   instr,
    sme_stream_if.source result
);

    localparam int REG_AW = $clog2(NUM_REGS);
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int BW     = sme_pkg::BYTE_W;

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic                  e_valid_reg;
    sme_pkg::instr_t       e_instr_reg;
    logic                  out_valid_reg;
    sme_pkg::result_t      out_data_reg;
    sme_pkg::result_t      out_data_next;

    logic out_free;
    logic e_fire;
    logic acc;

    // The output register can take a new result when it is empty or its
    // current result is being taken in this cycle.
    assign out_free = !out_valid_reg || result.ready;
    assign e_fire   = e_valid_reg && out_free;
    assign acc      = instr.valid && instr.ready;

    assign instr.ready  = !e_valid_reg || out_free;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [BW-1:0]        pc_reg;
    logic [BW-1:0]        pc_next;
    logic                 halt_reg;
    logic [BW-1:0]        reg0_reg;
    logic [NUM_REGS-1:0]  rf_valid_reg;
    logic [MEM_DEPTH-1:0] dm_valid_reg;

    // ------------------------------------------------------------------
    // Read addresses, taken from the instruction being accepted
    // ------------------------------------------------------------------
    logic [3:0]        in_op;
    logic [REG_AW-1:0] rfa_raddr;
    logic [REG_AW-1:0] rfb_raddr;
    logic [MEM_AW-1:0] dm_raddr;

    assign in_op = instr.data.instruction[15:12];

    // Port A serves the first source of move and add, and the R operand of
    // store and jump. Port B serves the second source of add.
    assign rfa_raddr = ((in_op == sme_pkg::OP_MOVE) || (in_op == sme_pkg::OP_ADD))
                       ? REG_AW'(instr.data.instruction[7:4])
                       : REG_AW'(instr.data.instruction[11:8]);
    assign rfb_raddr = REG_AW'(instr.data.instruction[3:0]);
    assign dm_raddr  = MEM_AW'(instr.data.instruction[7:0]);

    // ------------------------------------------------------------------
    // Write ports, driven by the instruction that executes this cycle
    // ------------------------------------------------------------------
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [BW-1:0]     rf_wdata;
    logic              dm_we;
    logic [MEM_AW-1:0] dm_waddr;
    logic [BW-1:0]     dm_wdata;

    // Registered read data and the bypass captured at accept time. A write
    // from the executing instruction to the address being read in the same
    // cycle is forwarded, since the RAM would return the old contents.
    logic [BW-1:0] rfa_q;
    logic [BW-1:0] rfb_q;
    logic [BW-1:0] dm_q;
    logic          rfa_byp_reg;
    logic          rfb_byp_reg;
    logic          dm_byp_reg;
    logic          rfa_vld_reg;
    logic          rfb_vld_reg;
    logic          dm_vld_reg;
    logic [BW-1:0] rfa_bval_reg;
    logic [BW-1:0] rfb_bval_reg;
    logic [BW-1:0] dm_bval_reg;

    sme_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_REGS)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (acc),
        .raddr (rfa_raddr),
        .rdata (rfa_q)
    );

    sme_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_REGS)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (acc),
        .raddr (rfb_raddr),
        .rdata (rfb_q)
    );

    sme_ram #(
        .WIDTH (BW),
        .DEPTH (MEM_DEPTH)
    ) u_dm (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (acc),
        .raddr (dm_raddr),
        .rdata (dm_q)
    );

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic [3:0]    e_op;
    logic [3:0]    e_r;
    logic [3:0]    e_t;
    logic [BW-1:0] e_xy;
    logic [BW-1:0] rf_a;
    logic [BW-1:0] rf_b;
    logic [BW-1:0] dm_rd;
    logic          wr;
    logic          halt_set;

    assign e_op = e_instr_reg.instruction[15:12];
    assign e_r  = e_instr_reg.instruction[11:8];
    assign e_t  = e_instr_reg.instruction[3:0];
    assign e_xy = e_instr_reg.instruction[7:0];

    // A register or byte that was never written reads as zero.
    assign rf_a  = rfa_byp_reg ? rfa_bval_reg : (rfa_vld_reg ? rfa_q : '0);
    assign rf_b  = rfb_byp_reg ? rfb_bval_reg : (rfb_vld_reg ? rfb_q : '0);
    assign dm_rd = dm_byp_reg  ? dm_bval_reg  : (dm_vld_reg  ? dm_q  : '0);

    always_comb
    begin
        pc_next                 = pc_reg + BW'(2);
        wr                      = 1'b0;
        halt_set                = 1'b0;
        out_data_next           = '0;
        dm_we                   = 1'b0;
        dm_waddr                = MEM_AW'(e_xy);
        dm_wdata                = rf_a;
        rf_waddr                = REG_AW'(e_r);
        rf_wdata                = '0;
        out_data_next.reg_index = e_r;

        case (e_op)
            sme_pkg::OP_LOAD_MEM:
            begin
                wr       = 1'b1;
                rf_wdata = dm_rd;
            end
            sme_pkg::OP_LOAD_IMM:
            begin
                wr       = 1'b1;
                rf_wdata = e_xy;
            end
            sme_pkg::OP_STORE:
            begin
                dm_we = 1'b1;
            end
            sme_pkg::OP_MOVE:
            begin
                wr                      = 1'b1;
                rf_waddr                = REG_AW'(e_t);
                out_data_next.reg_index = e_t;
                rf_wdata                = rf_a;
            end
            sme_pkg::OP_ADD:
            begin
                wr       = 1'b1;
                rf_wdata = rf_a + rf_b;
            end
            sme_pkg::OP_JUMP:
            begin
                if (rf_a == reg0_reg)
                begin
                    pc_next = e_xy;
                end
            end
            sme_pkg::OP_HALT:
            begin
                halt_set = 1'b1;
            end
            default:
            begin
                out_data_next.illegal = 1'b1;
            end
        endcase

        out_data_next.next_pc   = pc_next;
        out_data_next.halted    = halt_set;
        out_data_next.reg_write = wr;
        out_data_next.reg_value = rf_wdata;
        if (!wr)
        begin
            out_data_next.reg_index = '0;
        end

        // Once halted, the instruction is ignored and the held pc is reported.
        if (halt_reg)
        begin
            pc_next               = pc_reg;
            wr                    = 1'b0;
            dm_we                 = 1'b0;
            halt_set              = 1'b0;
            out_data_next         = '0;
            out_data_next.next_pc = pc_reg;
            out_data_next.halted  = 1'b1;
        end

        rf_we = e_fire && wr;
        dm_we = e_fire && dm_we;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            reg0_reg      <= '0;
            rf_valid_reg  <= '0;
            dm_valid_reg  <= '0;
            rfa_byp_reg   <= 1'b0;
            rfb_byp_reg   <= 1'b0;
            dm_byp_reg    <= 1'b0;
            rfa_vld_reg   <= 1'b0;
            rfb_vld_reg   <= 1'b0;
            dm_vld_reg    <= 1'b0;
        end
        else
        begin
            if (instr.ready)
            begin
                e_valid_reg <= instr.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= e_valid_reg;
            end
            if (e_fire)
            begin
                pc_reg   <= pc_next;
                halt_reg <= halt_reg || halt_set;
            end
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
                if (rf_waddr == '0)
                begin
                    reg0_reg <= rf_wdata;
                end
            end
            if (dm_we)
            begin
                dm_valid_reg[dm_waddr] <= 1'b1;
            end
            if (acc)
            begin
                rfa_byp_reg <= rf_we && (rf_waddr == rfa_raddr);
                rfb_byp_reg <= rf_we && (rf_waddr == rfb_raddr);
                dm_byp_reg  <= dm_we && (dm_waddr == dm_raddr);
                rfa_vld_reg <= rf_valid_reg[rfa_raddr];
                rfb_vld_reg <= rf_valid_reg[rfb_raddr];
                dm_vld_reg  <= dm_valid_reg[dm_raddr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            e_instr_reg  <= instr.data;
            rfa_bval_reg <= rf_wdata;
            rfb_bval_reg <= rf_wdata;
            dm_bval_reg  <= dm_wdata;
        end
        if (e_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_after_halt: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> (!rf_we && !dm_we))
        else $error("state written after halt");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    a_stall_holds_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !out_free) |=> (e_valid_reg && $stable(e_instr_reg)))
        else $error("execute register changed while stalled");

    a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.illegal && out_data_reg.reg_write))
        else $error("illegal instruction reported a register write");

endmodule

/* hw/rtl/sme_ram.sv */
// ============================================================================
// sme_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module sme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
